[rtl/gpu_write_epoch_hazard_tracker_core_assert.svh]
// assertion macros shared by the tracker rtl
`ifndef GPU_WRITE_EPOCH_HAZARD_TRACKER_CORE_ASSERT_SVH
`define GPU_WRITE_EPOCH_HAZARD_TRACKER_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define GWEHT_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("gweht assertion failed");

// next-cycle implication, checked outside reset
`define GWEHT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("gweht assertion failed");

`endif

[rtl/gweht_pkg.sv]
package gweht_pkg;

  localparam int FieldW        = 16;
  localparam int StageBitsDef  = 16;

  // command codes
  localparam logic [1:0] CMD_QUERY   = 2'd0;
  localparam logic [1:0] CMD_ACCESS  = 2'd1;
  localparam logic [1:0] CMD_BARRIER = 2'd2;

  // access bit positions
  localparam int AccRd = 0;
  localparam int AccWr = 1;

  localparam logic [1:0] ACC_NONE  = 2'b00;
  localparam logic [1:0] ACC_READ  = 2'b01;
  localparam logic [1:0] ACC_WRITE = 2'b10;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [FieldW-1:0] stage_mask;
    logic [1:0]        access_kind;
    logic [FieldW-1:0] broadened_read_mask;
    logic [FieldW-1:0] barrier_src_stages;
    logic [1:0]        barrier_src_access;
    logic [FieldW-1:0] barrier_dst_stages;
    logic [1:0]        barrier_dst_access;
  } gweht_in_t;

  typedef struct packed {
    logic [FieldW-1:0] need_src_stages;
    logic [1:0]        need_src_access;
    logic [FieldW-1:0] need_dst_stages;
    logic [1:0]        need_dst_access;
    logic [FieldW-1:0] epoch_writer_stages;
    logic [FieldW-1:0] epoch_reader_stages;
    logic [FieldW-1:0] epoch_visible_stages;
    logic [FieldW-1:0] all_read_stages;
    logic [FieldW-1:0] all_write_stages;
    logic [FieldW-1:0] early_read_stages;
    logic [FieldW-1:0] early_write_stages;
  } gweht_out_t;

endpackage

[rtl/gweht_epoch.sv]
module gweht_epoch
  import gweht_pkg::*;
#(
  parameter int STAGE_BITS = StageBitsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_en_i,
  input  gweht_in_t  word_i,
  output gweht_out_t result_o
);

  localparam int StageW = (STAGE_BITS < FieldW) ? STAGE_BITS : FieldW;

  logic [StageW-1:0] writer_q, writer_d;
  logic [StageW-1:0] reader_q, reader_d;
  logic [StageW-1:0] visible_q, visible_d;
  logic [StageW-1:0] hist_rd_q, hist_rd_d;
  logic [StageW-1:0] hist_wr_q, hist_wr_d;
  logic [StageW-1:0] early_rd_q, early_rd_d;
  logic [StageW-1:0] early_wr_q, early_wr_d;
  logic              bar_seen_q, bar_seen_d;

  logic [StageW-1:0] stages, broad, bsrc, bdst, missing, src_all;
  logic [StageW-1:0] n_src, n_dst;
  logic [1:0]        n_src_acc, n_dst_acc;

  assign stages  = word_i.stage_mask[StageW-1:0];
  assign broad   = word_i.broadened_read_mask[StageW-1:0];
  assign bsrc    = word_i.barrier_src_stages[StageW-1:0];
  assign bdst    = word_i.barrier_dst_stages[StageW-1:0];
  assign missing = stages & ~visible_q;
  assign src_all = writer_q | reader_q;

  always_comb begin
    writer_d   = writer_q;
    reader_d   = reader_q;
    visible_d  = visible_q;
    hist_rd_d  = hist_rd_q;
    hist_wr_d  = hist_wr_q;
    early_rd_d = early_rd_q;
    early_wr_d = early_wr_q;
    bar_seen_d = bar_seen_q;
    n_src      = '0;
    n_dst      = '0;
    n_src_acc  = ACC_NONE;
    n_dst_acc  = ACC_NONE;
    case (word_i.cmd)
      CMD_QUERY: begin
        if (word_i.access_kind[AccWr]) begin
          if (src_all != '0) begin
            n_src                = src_all;
            n_src_acc[AccWr]     = (writer_q != '0);
            n_src_acc[AccRd]     = (reader_q != '0);
            n_dst                = stages;
            n_dst_acc            = word_i.access_kind;
          end
        end else if (word_i.access_kind[AccRd]) begin
          if (writer_q != '0 && missing != '0) begin
            n_src     = writer_q;
            n_src_acc = ACC_WRITE;
            n_dst     = missing | (broad & ~visible_q);
            n_dst_acc = ACC_READ;
          end
        end
      end
      CMD_ACCESS: begin
        if (word_i.access_kind[AccRd]) hist_rd_d = hist_rd_q | stages;
        if (word_i.access_kind[AccWr]) hist_wr_d = hist_wr_q | stages;
        if (!bar_seen_q) begin
          if (word_i.access_kind[AccRd]) early_rd_d = early_rd_q | stages;
          if (word_i.access_kind[AccWr]) early_wr_d = early_wr_q | stages;
        end
        if (word_i.access_kind[AccWr]) begin
          // a write opens a new epoch
          writer_d  = stages;
          reader_d  = '0;
          visible_d = '0;
        end else begin
          reader_d = reader_q | stages;
        end
      end
      CMD_BARRIER: begin
        if (word_i.barrier_src_access[AccWr] && word_i.barrier_dst_access[AccRd] &&
            writer_q != '0 && (writer_q & ~bsrc) == '0) begin
          visible_d = visible_q | bdst;
        end
        if (bdst != '0) bar_seen_d = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      writer_q   <= '0;
      reader_q   <= '0;
      visible_q  <= '0;
      hist_rd_q  <= '0;
      hist_wr_q  <= '0;
      early_rd_q <= '0;
      early_wr_q <= '0;
      bar_seen_q <= 1'b0;
    end else if (step_en_i) begin
      writer_q   <= writer_d;
      reader_q   <= reader_d;
      visible_q  <= visible_d;
      hist_rd_q  <= hist_rd_d;
      hist_wr_q  <= hist_wr_d;
      early_rd_q <= early_rd_d;
      early_wr_q <= early_wr_d;
      bar_seen_q <= bar_seen_d;
    end
  end

  always_comb begin
    result_o.need_src_stages      = FieldW'(n_src);
    result_o.need_src_access      = n_src_acc;
    result_o.need_dst_stages      = FieldW'(n_dst);
    result_o.need_dst_access      = n_dst_acc;
    result_o.epoch_writer_stages  = FieldW'(writer_d);
    result_o.epoch_reader_stages  = FieldW'(reader_d);
    result_o.epoch_visible_stages = FieldW'(visible_d);
    result_o.all_read_stages      = FieldW'(hist_rd_d);
    result_o.all_write_stages     = FieldW'(hist_wr_d);
    result_o.early_read_stages    = FieldW'(early_rd_d);
    result_o.early_write_stages   = FieldW'(early_wr_d);
  end

`include "gpu_write_epoch_hazard_tracker_core_assert.svh"

  `GWEHT_ASSERT_NEXT(a_write_clears_epoch, clk_i, rst_ni,
    step_en_i && word_i.cmd == CMD_ACCESS && word_i.access_kind[AccWr],
    reader_q == '0 && visible_q == '0)
  `GWEHT_ASSERT_NOW(a_visible_needs_writer, clk_i, rst_ni,
    visible_q != '0, writer_q != '0)
  `GWEHT_ASSERT_NOW(a_early_within_history, clk_i, rst_ni,
    1'b1, (early_rd_q & ~hist_rd_q) == '0 && (early_wr_q & ~hist_wr_q) == '0)

endmodule

[rtl/gpu_write_epoch_hazard_tracker_core.sv]
// write-epoch hazard tracker for one gpu resource
//
// input channel: in_valid_i / in_stall_o carry one command word per handshake
// (query required barrier, record access, record barrier). output channel:
// out_valid_o / out_stall_i carry one result word for every command word.
//
// a word accepted into the input register is evaluated against the epoch
// state as it moves into the result register, which drives out_word_o.
// throughput: one word per cycle while out_stall_i does not hold the result
// register; the step logic is a handful of mask ops, at most 16 bits wide,
// between the input register and the result register.
// reset clears the epoch, history and early masks and both pipeline stages.
// when the receiver stalls, the result register holds; one more word waits
// in the input register, and only then is in_stall_o raised.
// a cmd value with no meaning changes nothing and returns the held state.
module gpu_write_epoch_hazard_tracker_core
  import gweht_pkg::*;
#(
  parameter int STAGE_BITS = StageBitsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  gweht_in_t  in_word_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output gweht_out_t out_word_o
);

  // input register
  gweht_in_t  in_q;
  logic       in_valid_q, in_valid_d;
  // result register
  gweht_out_t res_q;
  logic       res_valid_q, res_valid_d;

  gweht_out_t step_res;
  logic       res_load;   // result register free this cycle
  logic       step_go;    // input word moves into the result register
  logic       in_take;    // new word accepted

  assign res_load   = !res_valid_q || !out_stall_i;
  assign step_go    = in_valid_q && res_load;
  assign in_stall_o = in_valid_q && !res_load;
  assign in_take    = in_valid_i && !in_stall_o;

  // epoch state and the per-word step logic; state advances with step_go
  gweht_epoch #(
    .STAGE_BITS (STAGE_BITS)
  ) u_epoch (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_en_i (step_go),
    .word_i    (in_q),
    .result_o  (step_res)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (step_go) begin
      in_valid_d = 1'b0;
    end
    res_valid_d = res_valid_q;
    if (step_go) begin
      res_valid_d = 1'b1;
    end else if (res_load) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      res_valid_q <= res_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_word_i;
    end
    if (step_go) begin
      res_q <= step_res;
    end
  end

  assign out_valid_o = res_valid_q;
  assign out_word_o  = res_q;

`include "gpu_write_epoch_hazard_tracker_core_assert.svh"

  `GWEHT_ASSERT_NOW(a_stall_only_when_full, clk_i, rst_ni,
    in_stall_o, in_valid_q && res_valid_q)
  `GWEHT_ASSERT_NEXT(a_stalled_input_kept, clk_i, rst_ni,
    in_valid_q && !step_go, in_valid_q)
  `GWEHT_ASSERT_NEXT(a_step_fills_result, clk_i, rst_ni,
    step_go, res_valid_q)

endmodule
